// ===== hw/rtl/timed_pump_run_scheduler_macros.svh =====
// Assertion macros for the timed pump run scheduler.
// Used by the top level only; no other dependencies.
`ifndef TIMED_PUMP_RUN_SCHEDULER_MACROS_SVH
`define TIMED_PUMP_RUN_SCHEDULER_MACROS_SVH

// same-cycle implication, disabled while reset is active
`define TPRS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tprs: same-cycle check failed");

// next-cycle implication, disabled while reset is active
`define TPRS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tprs: next-cycle check failed");

`endif

// ===== hw/rtl/tprs_pkg.sv =====
// Shared types and constants for the timed pump run scheduler.
// No dependencies; imported by the top level, the controller and the datapath.
`default_nettype none

package tprs_pkg;

	// field widths
	localparam int DATE_W   = 5;
	localparam int HOUR_W   = 5;
	localparam int MIN_W    = 6;
	localparam int COUNT_W  = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_VAL_W = 6;

	// divider runs one bit of the date per step
	localparam int DIV_STEPS = DATE_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// timing constants
	localparam logic [MIN_W-1:0] RESET_SECOND_WINDOW   = 6'd2;
	localparam logic [MIN_W-1:0] DRY_CHECK_SECOND      = 6'd10;
	localparam logic [MIN_W-1:0] RECOVERY_LEAD_MINUTES = 6'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_START_HOUR    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_MINUTE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RUN_MINUTES   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DAY_DIVISOR   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DRST_HOUR     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_DRST_MINUTE   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_MRST_DATE     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY_HRS  = 3'd7;

	// configuration reset values
	localparam logic [HOUR_W-1:0] RST_START_HOUR   = 5'd2;
	localparam logic [MIN_W-1:0]  RST_START_MINUTE = 6'd0;
	localparam logic [MIN_W-1:0]  RST_RUN_MINUTES  = 6'd3;
	localparam logic [DATE_W-1:0] RST_DAY_DIVISOR  = 5'd3;
	localparam logic [HOUR_W-1:0] RST_DRST_HOUR    = 5'd1;
	localparam logic [MIN_W-1:0]  RST_DRST_MINUTE  = 6'd0;
	localparam logic [DATE_W-1:0] RST_MRST_DATE    = 5'd1;
	localparam logic [HOUR_W-1:0] RST_RECOVERY_HRS = 5'd4;

	// command codes
	localparam logic CMD_POWER_UP = 1'b0;
	localparam logic CMD_POLL     = 1'b1;

	typedef struct packed {
		logic               command;
		logic [DATE_W-1:0]  date;
		logic [HOUR_W-1:0]  hour;
		logic [MIN_W-1:0]   minute;
		logic [MIN_W-1:0]   second;
		logic               sensor_dry;
		logic [COUNT_W-1:0] saved_count;
		logic               saved_done;
	} in_item_t;

	typedef struct packed {
		logic               relay_drive;
		logic               sensor_enable;
		logic               beep;
		logic [COUNT_W-1:0] count_now;
		logic               done_now;
		logic               store_count;
		logic               store_done;
	} result_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [CFG_VAL_W-1:0] value;
	} cfg_item_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic step;
		logic commit;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_last;
	} dp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tprs_chan_if.sv =====
// Valid/ready channel carrying one item of type T.
// Depends on nothing; payload types come from tprs_pkg at instantiation.
`default_nettype none

interface tprs_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/timed_pump_run_scheduler.sv =====
// Timed pump run scheduler, top level.
// Each item is loaded, taken through 5 bit-serial date divide steps, then committed.
// A new item is taken only after the last commits; commit waits until the output is free.
// A finished result waits in the output register while the next item is taken.
// Reset (arst_n low, asynchronous): config to defaults, relay off, water ok, count 0.
`default_nettype none

`include "timed_pump_run_scheduler_macros.svh"

module timed_pump_run_scheduler
	import tprs_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	tprs_chan_if.sink   item_in,
	tprs_chan_if.source result_out,
	tprs_chan_if.sink   cfg
);

	dp_cmd_t    cmd;
	dp_status_t status;
	logic       in_ready;
	logic       out_valid;
	result_t    res;

	// config writes are always taken
	assign cfg.ready = 1'b1;

	tprs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item_in.valid),
		.in_ready  (in_ready),
		.out_ready (result_out.ready),
		.out_valid (out_valid),
		.status    (status),
		.cmd       (cmd)
	);

	tprs_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.in_data  (item_in.data),
		.cfg_we   (cfg.valid),
		.cfg_data (cfg.data),
		.res      (res)
	);

	assign item_in.ready    = in_ready;
	assign result_out.valid = out_valid;
	assign result_out.data  = res;

	// checks
	`TPRS_ASSERT_NEXT(a_accept_blocks, clk, arst_n, item_in.valid && item_in.ready, !item_in.ready)
	`TPRS_ASSERT_IMP(a_beep_relay, clk, arst_n, result_out.valid && result_out.data.beep, result_out.data.relay_drive)
	`TPRS_ASSERT_IMP(a_sensor_relay, clk, arst_n, result_out.valid, result_out.data.sensor_enable == result_out.data.relay_drive)

endmodule

`default_nettype wire

// ===== hw/rtl/tprs_ctrl.sv =====
// Controller for the pump scheduler: sequences load, date divide and commit.
// Depends on tprs_pkg.
`default_nettype none

module tprs_ctrl
	import tprs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       out_ready,
	output logic            out_valid,
	input  wire dp_status_t status,
	output dp_cmd_t         cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_EXEC = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;

	// commands
	always_comb begin
		in_ready   = (state_q == ST_IDLE);
		cmd.load   = in_valid && in_ready;
		cmd.step   = (state_q == ST_DIV);
		cmd.commit = (state_q == ST_EXEC) && (!out_valid_q || out_ready);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.load) state_d = ST_DIV;
			end
			ST_DIV: begin
				if (status.div_last) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (cmd.commit) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== hw/rtl/tprs_dp.sv =====
// Datapath for the pump scheduler: config registers, item latch, bit-serial
// date remainder, scheduling rules and result register. Depends on tprs_pkg.
`default_nettype none

module tprs_dp
	import tprs_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire dp_cmd_t   cmd,
	output dp_status_t     status,
	input  wire in_item_t  in_data,
	input  wire logic      cfg_we,
	input  wire cfg_item_t cfg_data,
	output result_t        res
);

	typedef struct packed {
		logic [HOUR_W-1:0] hour;
		logic [MIN_W-1:0]  minute;
	} hm_t;

	// minute add with carry into the hour, hour wraps once at 24
	function automatic hm_t add_minutes(input logic [HOUR_W-1:0] h,
		input logic [MIN_W-1:0] m, input logic [MIN_W-1:0] add);
		logic [MIN_W:0]    sum;
		logic [1:0]        q;
		logic [MIN_W:0]    rem;
		logic [HOUR_W:0]   hr;
		hm_t               r;
		sum = {1'b0, m} + {1'b0, add};
		if (sum >= 7'd120) begin
			q   = 2'd2;
			rem = sum - 7'd120;
		end else if (sum >= 7'd60) begin
			q   = 2'd1;
			rem = sum - 7'd60;
		end else begin
			q   = 2'd0;
			rem = sum;
		end
		hr = {1'b0, h} + {4'd0, q};
		if (hr >= 6'd24) hr = hr - 6'd24;
		r.hour   = hr[HOUR_W-1:0];
		r.minute = rem[MIN_W-1:0];
		return r;
	endfunction

	// configuration registers
	logic [HOUR_W-1:0] start_hour_q;
	logic [MIN_W-1:0]  start_minute_q;
	logic [MIN_W-1:0]  run_minutes_q;
	logic [DATE_W-1:0] day_divisor_q;
	logic [HOUR_W-1:0] drst_hour_q;
	logic [MIN_W-1:0]  drst_minute_q;
	logic [DATE_W-1:0] mrst_date_q;
	logic [HOUR_W-1:0] recovery_hrs_q;

	// scheduler state
	logic               relay_q;
	logic               done_q;
	logic               water_q;
	logic [COUNT_W-1:0] count_q;
	logic [HOUR_W-1:0]  sched_hour_q;
	logic [MIN_W-1:0]   sched_minute_q;

	// item latch and divider
	in_item_t           item_q;
	logic [DATE_W-1:0]  div_sh_q;
	logic [DATE_W-1:0]  rem_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	result_t            res_q;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_hour_q   <= RST_START_HOUR;
			start_minute_q <= RST_START_MINUTE;
			run_minutes_q  <= RST_RUN_MINUTES;
			day_divisor_q  <= RST_DAY_DIVISOR;
			drst_hour_q    <= RST_DRST_HOUR;
			drst_minute_q  <= RST_DRST_MINUTE;
			mrst_date_q    <= RST_MRST_DATE;
			recovery_hrs_q <= RST_RECOVERY_HRS;
		end else if (cfg_we) begin
			unique case (cfg_data.index)
				CFG_START_HOUR:   start_hour_q   <= cfg_data.value[HOUR_W-1:0];
				CFG_START_MINUTE: start_minute_q <= cfg_data.value;
				CFG_RUN_MINUTES:  run_minutes_q  <= cfg_data.value;
				CFG_DAY_DIVISOR:  day_divisor_q  <= cfg_data.value[DATE_W-1:0];
				CFG_DRST_HOUR:    drst_hour_q    <= cfg_data.value[HOUR_W-1:0];
				CFG_DRST_MINUTE:  drst_minute_q  <= cfg_data.value;
				CFG_MRST_DATE:    mrst_date_q    <= cfg_data.value[DATE_W-1:0];
				CFG_RECOVERY_HRS: recovery_hrs_q <= cfg_data.value[HOUR_W-1:0];
				default: ;
			endcase
		end
	end

	// restoring remainder step: one date bit per cycle
	logic [DATE_W-1:0] divisor;
	logic [DATE_W:0]   trial;
	logic [DATE_W-1:0] rem_next;

	always_comb begin
		divisor = (day_divisor_q == '0) ? DATE_W'(1) : day_divisor_q;
		trial   = {rem_q, div_sh_q[DATE_W-1]};
		if (trial >= {1'b0, divisor}) begin
			rem_next = DATE_W'(trial - {1'b0, divisor});
		end else begin
			rem_next = trial[DATE_W-1:0];
		end
	end

	assign status.div_last = (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q    <= in_data;
			div_sh_q  <= in_data.date;
			rem_q     <= '0;
			div_cnt_q <= '0;
		end else if (cmd.step) begin
			div_sh_q  <= {div_sh_q[DATE_W-2:0], 1'b0};
			rem_q     <= rem_next;
			div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
		end
	end

	// scheduling rules for the latched item
	logic               date_ok;
	logic               reset_time;
	logic               n_relay;
	logic               n_done;
	logic               n_water;
	logic [COUNT_W-1:0] n_count;
	logic [HOUR_W-1:0]  n_sh;
	logic [MIN_W-1:0]   n_sm;
	logic               n_beep;
	logic               n_stc;
	logic               n_std;
	logic [HOUR_W:0]    win_end;
	hm_t                lead;
	hm_t                stop;

	always_comb begin
		date_ok    = (rem_q == '0);
		reset_time = (item_q.hour == drst_hour_q) && (item_q.minute == drst_minute_q) &&
			(item_q.second < RESET_SECOND_WINDOW);
		win_end    = {1'b0, start_hour_q} + {1'b0, recovery_hrs_q};
		lead       = add_minutes(item_q.hour, item_q.minute, RECOVERY_LEAD_MINUTES);
		n_relay    = relay_q;
		n_done     = done_q;
		n_water    = water_q;
		n_count    = count_q;
		n_sh       = sched_hour_q;
		n_sm       = sched_minute_q;
		n_beep     = 1'b0;
		n_stc      = 1'b0;
		n_std      = 1'b0;
		stop       = '0;
		if (item_q.command == CMD_POWER_UP) begin
			n_relay = 1'b0;
			n_water = 1'b1;
			n_count = item_q.saved_count;
			n_done  = item_q.saved_done;
			n_sh    = start_hour_q;
			n_sm    = start_minute_q;
			if (item_q.hour >= start_hour_q && {1'b0, item_q.hour} < win_end &&
				!item_q.saved_done) begin
				n_sh = lead.hour;
				n_sm = lead.minute;
			end
		end else begin
			// daily reset
			if (reset_time && done_q) begin
				n_done  = 1'b0;
				n_water = 1'b1;
				n_std   = 1'b1;
				n_sh    = start_hour_q;
				n_sm    = start_minute_q;
			end
			// monthly reset
			if (reset_time && item_q.date == mrst_date_q) begin
				n_count = '0;
				n_stc   = 1'b1;
			end
			stop = add_minutes(n_sh, n_sm, run_minutes_q);
			if (!relay_q) begin
				// start rule
				if (date_ok && item_q.hour == n_sh && item_q.minute == n_sm && n_water) begin
					n_relay = 1'b1;
					n_beep  = 1'b1;
				end
			end else begin
				// stop rule
				if (date_ok && item_q.hour == stop.hour && item_q.minute == stop.minute) begin
					n_relay = 1'b0;
					n_count = n_count + COUNT_W'(1);
					n_stc   = 1'b1;
					n_sh    = start_hour_q;
					n_sm    = start_minute_q;
					n_done  = 1'b1;
					n_std   = 1'b1;
				end
				// dry sensor check
				if (item_q.second >= DRY_CHECK_SECOND) begin
					if (item_q.sensor_dry) begin
						n_water = 1'b0;
						n_relay = 1'b0;
					end else begin
						n_water = 1'b1;
					end
				end
			end
		end
	end

	// state update on commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relay_q        <= 1'b0;
			done_q         <= 1'b0;
			water_q        <= 1'b1;
			count_q        <= '0;
			sched_hour_q   <= RST_START_HOUR;
			sched_minute_q <= RST_START_MINUTE;
		end else if (cmd.commit) begin
			relay_q        <= n_relay;
			done_q         <= n_done;
			water_q        <= n_water;
			count_q        <= n_count;
			sched_hour_q   <= n_sh;
			sched_minute_q <= n_sm;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_q.relay_drive   <= n_relay;
			res_q.sensor_enable <= n_relay;
			res_q.beep          <= n_beep;
			res_q.count_now     <= n_count;
			res_q.done_now      <= n_done;
			res_q.store_count   <= n_stc;
			res_q.store_done    <= n_std;
		end
	end

	assign res = res_q;

endmodule

`default_nettype wire

// ===== tb/sv/tprs_pump_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the timed pump run scheduler: follows register writes, predicts
// one result per accepted item and compares each returned result field by field.
// Depends on tprs_pkg for the item, result and register types.
module tprs_pump_checker
	import tprs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	input  logic      item_ready,
	input  in_item_t  item_data,
	input  logic      result_valid,
	input  logic      result_ready,
	input  result_t   result_data,
	input  logic      cfg_valid,
	input  logic      cfg_ready,
	input  cfg_item_t cfg_data,
	output int        fail_count,
	output int        results_pending,
	output int        results_seen,
	output int        pump_starts,
	output int        pump_stops
);

	// shadow copy of the schedule registers
	logic [HOUR_W-1:0]  start_hour_q, drst_hour_q, recovery_q;
	logic [MIN_W-1:0]   start_min_q, run_min_q, drst_min_q;
	logic [DATE_W-1:0]  day_div_q, mrst_date_q;

	// predicted pump state
	logic               relay_on, done_today, water_present;
	logic [COUNT_W-1:0] run_total;
	logic [HOUR_W-1:0]  sched_hour_q;
	logic [MIN_W-1:0]   sched_min_q;

	result_t            expected_results[$];

	// add minutes to a clock time, carrying into the hour and wrapping the day once
	function automatic logic [HOUR_W+MIN_W-1:0] clock_add(input int h, input int m, input int add);
		int sum, hr;
		sum = m + add;
		hr = h + sum / 60;
		if (hr >= 24)
			hr -= 24;
		return {HOUR_W'(hr), MIN_W'(sum % 60)};
	endfunction

	// advance the pump state by one item and return the result it produces
	task automatic pump_step(input in_item_t it, output result_t r);
		int div;
		logic date_hit, reset_time;
		logic [HOUR_W-1:0] stop_hour;
		logic [MIN_W-1:0] stop_min;
		r = '0;
		div = (day_div_q == 0) ? 1 : int'(day_div_q);
		date_hit = (int'(it.date) % div) == 0;
		if (it.command == CMD_POWER_UP) begin
			relay_on = 1'b0;
			water_present = 1'b1;
			run_total = it.saved_count;
			done_today = it.saved_done;
			sched_hour_q = start_hour_q;
			sched_min_q = start_min_q;
			// missed run inside the recovery window: start shortly after power-up
			if (it.hour >= start_hour_q && int'(it.hour) < int'(start_hour_q) + int'(recovery_q)
					&& !done_today)
				{sched_hour_q, sched_min_q} = clock_add(it.hour, it.minute,
					RECOVERY_LEAD_MINUTES);
		end else begin
			reset_time = it.hour == drst_hour_q && it.minute == drst_min_q &&
				it.second < RESET_SECOND_WINDOW;
			// daily reset
			if (reset_time && done_today) begin
				done_today = 1'b0;
				water_present = 1'b1;
				r.store_done = 1'b1;
				sched_hour_q = start_hour_q;
				sched_min_q = start_min_q;
			end
			// monthly reset
			if (reset_time && it.date == mrst_date_q) begin
				run_total = '0;
				r.store_count = 1'b1;
			end
			if (!relay_on) begin
				if (date_hit && it.hour == sched_hour_q && it.minute == sched_min_q &&
						water_present) begin
					relay_on = 1'b1;
					r.beep = 1'b1;
				end
			end else begin
				{stop_hour, stop_min} = clock_add(sched_hour_q, sched_min_q, run_min_q);
				if (date_hit && it.hour == stop_hour && it.minute == stop_min) begin
					relay_on = 1'b0;
					run_total = run_total + 8'd1;
					r.store_count = 1'b1;
					sched_hour_q = start_hour_q;
					sched_min_q = start_min_q;
					done_today = 1'b1;
					r.store_done = 1'b1;
					pump_stops++;
				end
				// sensor only counts once it has settled
				if (it.second >= DRY_CHECK_SECOND) begin
					if (it.sensor_dry) begin
						water_present = 1'b0;
						relay_on = 1'b0;
					end else begin
						water_present = 1'b1;
					end
				end
			end
		end
		r.relay_drive = relay_on;
		r.sensor_enable = relay_on;
		r.count_now = run_total;
		r.done_now = done_today;
	endtask

	task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		if (!arst_n) begin
			start_hour_q = RST_START_HOUR;
			start_min_q = RST_START_MINUTE;
			run_min_q = RST_RUN_MINUTES;
			day_div_q = RST_DAY_DIVISOR;
			drst_hour_q = RST_DRST_HOUR;
			drst_min_q = RST_DRST_MINUTE;
			mrst_date_q = RST_MRST_DATE;
			recovery_q = RST_RECOVERY_HRS;
			relay_on = 1'b0;
			done_today = 1'b0;
			water_present = 1'b1;
			run_total = '0;
			sched_hour_q = RST_START_HOUR;
			sched_min_q = RST_START_MINUTE;
			expected_results.delete();
			fail_count = 0;
			results_pending = 0;
			results_seen = 0;
			pump_starts = 0;
			pump_stops = 0;
		end else begin
			// returned result against the oldest prediction
			if (result_valid && result_ready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					$display("%0t: result with nothing expected, actual %h", $time, result_data);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					compare_field("relay_drive", want.relay_drive, result_data.relay_drive);
					compare_field("sensor_enable", want.sensor_enable, result_data.sensor_enable);
					compare_field("beep", want.beep, result_data.beep);
					compare_field("count_now", want.count_now, result_data.count_now);
					compare_field("done_now", want.done_now, result_data.done_now);
					compare_field("store_count", want.store_count, result_data.store_count);
					compare_field("store_done", want.store_done, result_data.store_done);
				end
			end
			// register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_data.index)
					CFG_START_HOUR:   start_hour_q = cfg_data.value[HOUR_W-1:0];
					CFG_START_MINUTE: start_min_q = cfg_data.value;
					CFG_RUN_MINUTES:  run_min_q = cfg_data.value;
					CFG_DAY_DIVISOR:  day_div_q = cfg_data.value[DATE_W-1:0];
					CFG_DRST_HOUR:    drst_hour_q = cfg_data.value[HOUR_W-1:0];
					CFG_DRST_MINUTE:  drst_min_q = cfg_data.value;
					CFG_MRST_DATE:    mrst_date_q = cfg_data.value[DATE_W-1:0];
					CFG_RECOVERY_HRS: recovery_q = cfg_data.value[HOUR_W-1:0];
					default: ;
				endcase
			end
			// accepted item
			if (item_valid && item_ready) begin
				pump_step(item_data, want);
				expected_results.push_back(want);
				if (want.beep)
					pump_starts++;
			end
			results_pending = expected_results.size();
		end
	end

endmodule

// ===== tb/sv/timed_pump_run_scheduler_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for timed_pump_run_scheduler: clock, reset, stimulus and verdict.
// Depends on tprs_pkg, tprs_chan_if, the scheduler RTL and tprs_pump_checker.
module timed_pump_run_scheduler_tb;
	import tprs_pkg::*;

	localparam int CYCLE_LIMIT     = 400000;
	localparam int RANDOM_PHASES   = 8;
	localparam int ITEMS_PER_PHASE = 225;

	logic clk, arst_n;
	int cycle_count;
	int send_idle_pct, recv_stall_pct, hold_request, hold_left;
	int fail_count, results_pending, results_seen, pump_starts, pump_stops;
	int items_sent, settings_count;
	// copies of the schedule registers, used to aim poll times
	int cfg_start_hour, cfg_start_minute, cfg_run_minutes, cfg_day_divisor;
	int cfg_drst_hour, cfg_drst_minute, cfg_mrst_date, cfg_recovery;
	int pu_hour, pu_minute;

	tprs_chan_if #(.T(in_item_t))  item_ch ();
	tprs_chan_if #(.T(result_t))   result_ch ();
	tprs_chan_if #(.T(cfg_item_t)) cfg_ch ();

	timed_pump_run_scheduler uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (item_ch),
		.result_out (result_ch),
		.cfg        (cfg_ch)
	);

	tprs_pump_checker pump_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_ch.valid),
		.item_ready      (item_ch.ready),
		.item_data       (item_ch.data),
		.result_valid    (result_ch.valid),
		.result_ready    (result_ch.ready),
		.result_data     (result_ch.data),
		.cfg_valid       (cfg_ch.valid),
		.cfg_ready       (cfg_ch.ready),
		.cfg_data        (cfg_ch.data),
		.fail_count      (fail_count),
		.results_pending (results_pending),
		.results_seen    (results_seen),
		.pump_starts     (pump_starts),
		.pump_stops      (pump_stops)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still expected", cycle_count,
				results_pending);
			$display("Regression FAIL");
			$finish;
		end
	end

	// result side: random stalls, plus long hold-offs counted here
	initial begin
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				result_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	function automatic in_item_t make_item(input logic cmd, input int date, input int hour,
			input int minute, input int second, input int dry, input int count, input int done);
		in_item_t it;
		it.command = cmd;
		it.date = DATE_W'(date);
		it.hour = HOUR_W'(hour);
		it.minute = MIN_W'(minute);
		it.second = MIN_W'(second);
		it.sensor_dry = 1'(dry);
		it.saved_count = COUNT_W'(count);
		it.saved_done = 1'(done);
		return it;
	endfunction

	// random item, mostly aimed at the start, stop and reset times of the schedule
	function automatic in_item_t pick_item();
		in_item_t it;
		int sel, h, m, dv;
		it = make_item(CMD_POLL, $urandom_range(31), $urandom_range(23), $urandom_range(59),
			$urandom_range(59), $urandom_range(99) < 12, $urandom_range(255), $urandom_range(1));
		dv = (cfg_day_divisor == 0) ? 1 : cfg_day_divisor;
		if ($urandom_range(99) < 75)
			it.date = DATE_W'(dv * $urandom_range(31 / dv));
		sel = $urandom_range(99);
		if (sel < 7) begin
			// power-up around the recovery window
			it.command = CMD_POWER_UP;
			it.hour = HOUR_W'(cfg_start_hour + $urandom_range(cfg_recovery));
			it.saved_done = ($urandom_range(99) < 30);
			pu_hour = it.hour;
			pu_minute = it.minute;
		end else if (sel < 65) begin
			// start time (default or recovered), or its stop time
			if ($urandom_range(1) == 0) begin
				h = cfg_start_hour;
				m = cfg_start_minute;
			end else begin
				h = pu_hour;
				m = pu_minute + RECOVERY_LEAD_MINUTES;
			end
			m += $urandom_range(1);
			if (sel >= 35)
				m += cfg_run_minutes;
			h = (h + m / 60) % 24;
			it.hour = HOUR_W'(h);
			it.minute = MIN_W'(m % 60);
		end else if (sel < 78) begin
			// daily reset time, sometimes on the monthly date
			it.hour = HOUR_W'(cfg_drst_hour);
			it.minute = MIN_W'(cfg_drst_minute);
			it.second = MIN_W'($urandom_range(3));
			if ($urandom_range(1))
				it.date = DATE_W'(cfg_mrst_date);
		end else if (sel < 88) begin
			// fields across their whole width
			it.date = DATE_W'($urandom_range(31));
			it.hour = HOUR_W'($urandom_range(31));
			it.minute = MIN_W'($urandom_range(63));
			it.second = MIN_W'($urandom_range(63));
		end
		return it;
	endfunction

	task automatic send_item(input in_item_t it);
		if ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			while ($urandom_range(99) < send_idle_pct)
				@(negedge clk);
			@(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data <= it;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= '{index: idx, value: CFG_VAL_W'(val)};
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// write all eight registers; the block must be idle
	task automatic write_schedule(input int sh, input int sm, input int run, input int div,
			input int rh, input int rm, input int md, input int rec);
		cfg_start_hour = sh & 31;
		cfg_start_minute = sm & 63;
		cfg_run_minutes = run & 63;
		cfg_day_divisor = div & 31;
		cfg_drst_hour = rh & 31;
		cfg_drst_minute = rm & 63;
		cfg_mrst_date = md & 31;
		cfg_recovery = rec & 31;
		cfg_write(CFG_START_HOUR, sh);
		cfg_write(CFG_START_MINUTE, sm);
		cfg_write(CFG_RUN_MINUTES, run);
		cfg_write(CFG_DAY_DIVISOR, div);
		cfg_write(CFG_DRST_HOUR, rh);
		cfg_write(CFG_DRST_MINUTE, rm);
		cfg_write(CFG_MRST_DATE, md);
		cfg_write(CFG_RECOVERY_HRS, rec);
		cfg_ch.valid <= 1'b0;
		settings_count++;
	endtask

	// stop offering items and let every predicted result come back
	task automatic wait_idle();
		item_ch.valid <= 1'b0;
		while (results_pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.data = '0;
		result_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		hold_request = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		items_sent = 0;
		settings_count = 1;
		pu_hour = 0;
		pu_minute = 0;
		cfg_start_hour = RST_START_HOUR;
		cfg_start_minute = RST_START_MINUTE;
		cfg_run_minutes = RST_RUN_MINUTES;
		cfg_day_divisor = RST_DAY_DIVISOR;
		cfg_drst_hour = RST_DRST_HOUR;
		cfg_drst_minute = RST_DRST_MINUTE;
		cfg_mrst_date = RST_MRST_DATE;
		cfg_recovery = RST_RECOVERY_HRS;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed, reset schedule; results held back at first so the block backs up
		hold_request = 200;
		// power-up inside the window but already done: no recovery
		send_item(make_item(CMD_POWER_UP, 3, 3, 10, 0, 0, 255, 1));
		// daily and monthly reset together; one second later is outside the window
		send_item(make_item(CMD_POLL, 1, 1, 0, 1, 0, 0, 0));
		send_item(make_item(CMD_POLL, 1, 1, 0, 2, 0, 0, 0));
		// start; dry before the check second is ignored; stop and dry in one poll
		send_item(make_item(CMD_POLL, 3, 2, 0, 0, 1, 0, 0));
		send_item(make_item(CMD_POLL, 3, 2, 1, 9, 1, 0, 0));
		send_item(make_item(CMD_POLL, 3, 2, 3, 45, 1, 0, 0));
		// no water blocks the start until the daily reset
		send_item(make_item(CMD_POLL, 6, 2, 0, 0, 0, 0, 0));
		send_item(make_item(CMD_POLL, 1, 1, 0, 0, 0, 0, 0));
		send_item(make_item(CMD_POLL, 6, 2, 0, 0, 0, 0, 0));
		// stop time on a date that does not divide; wet sensor; dry at second 63
		send_item(make_item(CMD_POLL, 4, 2, 3, 0, 0, 0, 0));
		send_item(make_item(CMD_POLL, 6, 2, 2, 10, 0, 0, 0));
		send_item(make_item(CMD_POLL, 6, 2, 2, 63, 1, 0, 0));
		// recovery start carried into the next hour, run on date zero
		send_item(make_item(CMD_POWER_UP, 5, 5, 58, 0, 0, 0, 0));
		send_item(make_item(CMD_POLL, 0, 6, 0, 0, 0, 0, 0));
		send_item(make_item(CMD_POLL, 0, 6, 3, 0, 0, 0, 0));
		// power-up at the end of the window
		send_item(make_item(CMD_POWER_UP, 6, 6, 0, 0, 0, 17, 0));
		wait_idle();

		// directed, late schedule with a zero divisor
		write_schedule(23, 59, 59, 0, 23, 59, 31, 23);
		// recovery start wraps past midnight, stop carries into the next hour
		send_item(make_item(CMD_POWER_UP, 7, 23, 59, 0, 0, 0, 0));
		send_item(make_item(CMD_POLL, 7, 0, 1, 0, 0, 0, 0));
		send_item(make_item(CMD_POLL, 7, 1, 0, 0, 0, 0, 0));
		// reset and start in the same poll, then stop with a wet check
		send_item(make_item(CMD_POLL, 31, 23, 59, 0, 0, 0, 0));
		send_item(make_item(CMD_POLL, 31, 0, 58, 11, 0, 0, 0));
		// fields above their range
		send_item(make_item(CMD_POWER_UP, 5, 31, 63, 63, 1, 128, 0));
		send_item(make_item(CMD_POLL, 5, 31, 63, 63, 1, 170, 1));

		// random phases over idling patterns and register settings
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			wait_idle();
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
				default: begin send_idle_pct = 34; recv_stall_pct = 34; end
			endcase
			if (p == 0)
				write_schedule(23, 59, 59, 31, 23, 59, 31, 23);
			else if (p == 1)
				write_schedule(0, 0, 1, 1, 0, 0, 1, 0);
			else if (p == 5)
				write_schedule($urandom_range(63), $urandom_range(63), $urandom_range(63),
					$urandom_range(63), $urandom_range(63), $urandom_range(63),
					$urandom_range(63), $urandom_range(63));
			else
				write_schedule($urandom_range(23), $urandom_range(59), $urandom_range(1, 59),
					$urandom_range(1, 6), $urandom_range(23), $urandom_range(59),
					$urandom_range(1, 31), $urandom_range(23));
			repeat (ITEMS_PER_PHASE)
				send_item(pick_item());
		end
		wait_idle();
		repeat (10) @(negedge clk);

		$display("Sent %0d items under %0d register settings; %0d results checked.",
			items_sent, settings_count, results_seen);
		$display("Pump starts %0d, completed runs %0d, mismatches %0d.",
			pump_starts, pump_stops, fail_count);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== timed_pump_run_scheduler.f =====
+incdir+hw/rtl
hw/rtl/tprs_pkg.sv
hw/rtl/tprs_chan_if.sv
hw/rtl/tprs_ctrl.sv
hw/rtl/tprs_dp.sv
hw/rtl/timed_pump_run_scheduler.sv
tb/sv/tprs_pump_checker.sv
tb/sv/timed_pump_run_scheduler_tb.sv
